// ===== rtl/cse_pkg.sv =====
// Shared constants, types and state encoding of the counting sort engine.
package cse_pkg;

	localparam int KEY_BITS = 8;
	localparam int MAX_ITEMS = 64;
	localparam int FIELD_BITS = 8;
	localparam int NUM_BUCKETS = 1 << KEY_BITS;
	localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);

	typedef logic [KEY_BITS-1:0] bucket_idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN_RD,
		ST_SCAN_LOAD,
		ST_SCAN_EMIT
	} cse_state_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] key;
		logic                  end_run;
		logic                  ovf;
	} cse_result_t;

endpackage

// ===== rtl/cse_core.sv =====
// Histogram memory with its read-modify-write and bucket scan sequencer.
module cse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_key,
	input  logic                in_last,
	output logic                in_ready,
	output logic                load_valid,
	output cse_pkg::cse_result_t load_data,
	input  logic                load_ready
);

	logic [cse_pkg::COUNT_BITS-1:0] mem [cse_pkg::NUM_BUCKETS];

	cse_pkg::cse_state_t  state_q, state_nxt;
	cse_pkg::bucket_idx_t bucket_q;
	cse_pkg::bucket_idx_t key_q;
	cse_pkg::bucket_idx_t largest_q;
	cse_pkg::count_t      items_q;
	cse_pkg::count_t      emitted_q;
	cse_pkg::count_t      rem_q;
	cse_pkg::count_t      rdata_q;
	logic                 last_q;
	logic                 drop_q;

	cse_pkg::bucket_idx_t in_bucket;
	cse_pkg::bucket_idx_t rd_addr;
	cse_pkg::bucket_idx_t wr_addr;
	cse_pkg::count_t      wr_data;
	logic                 wr_en;
	logic                 accept;
	logic                 room;
	logic                 scan_end;

	assign in_bucket = in_key[cse_pkg::KEY_BITS-1:0];
	assign accept    = in_valid && in_ready;
	assign room      = items_q != cse_pkg::count_t'(cse_pkg::MAX_ITEMS);
	assign scan_end  = bucket_q == largest_q;

	// Memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cse_pkg::ST_CLEAR: begin
				if (bucket_q == cse_pkg::bucket_idx_t'(cse_pkg::NUM_BUCKETS - 1)) begin
					state_nxt = cse_pkg::ST_IDLE;
				end
			end
			cse_pkg::ST_IDLE: begin
				if (accept) begin
					if (room) begin
						state_nxt = cse_pkg::ST_UPDATE;
					end else if (in_last) begin
						state_nxt = cse_pkg::ST_SCAN_RD;
					end
				end
			end
			cse_pkg::ST_UPDATE: begin
				state_nxt = last_q ? cse_pkg::ST_SCAN_RD : cse_pkg::ST_IDLE;
			end
			cse_pkg::ST_SCAN_RD: begin
				state_nxt = cse_pkg::ST_SCAN_LOAD;
			end
			cse_pkg::ST_SCAN_LOAD: begin
				if (rdata_q != '0) begin
					state_nxt = cse_pkg::ST_SCAN_EMIT;
				end else begin
					state_nxt = scan_end ? cse_pkg::ST_IDLE : cse_pkg::ST_SCAN_RD;
				end
			end
			cse_pkg::ST_SCAN_EMIT: begin
				if (load_ready && rem_q == cse_pkg::count_t'(1)) begin
					state_nxt = scan_end ? cse_pkg::ST_IDLE : cse_pkg::ST_SCAN_RD;
				end
			end
			default: state_nxt = cse_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		load_valid = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = bucket_q;
		wr_data    = '0;
		rd_addr    = bucket_q;
		unique case (state_q)
			cse_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			cse_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = in_bucket;
			end
			cse_pkg::ST_UPDATE: begin
				wr_en   = 1'b1;
				wr_addr = key_q;
				wr_data = rdata_q + cse_pkg::count_t'(1);
			end
			cse_pkg::ST_SCAN_RD: begin
			end
			cse_pkg::ST_SCAN_LOAD: begin
				// The scan empties each bucket it visits, leaving the histogram clear.
				wr_en = 1'b1;
			end
			cse_pkg::ST_SCAN_EMIT: begin
				load_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign load_data.key     = cse_pkg::FIELD_BITS'(bucket_q);
	assign load_data.end_run = (emitted_q + cse_pkg::count_t'(1)) == items_q;
	assign load_data.ovf     = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cse_pkg::ST_CLEAR;
			bucket_q  <= '0;
			largest_q <= '0;
			items_q   <= '0;
			emitted_q <= '0;
			drop_q    <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// The run ends once its last bucket has been emitted.
			if ((state_q == cse_pkg::ST_SCAN_LOAD || state_q == cse_pkg::ST_SCAN_EMIT)
					&& state_nxt == cse_pkg::ST_IDLE) begin
				bucket_q  <= '0;
				largest_q <= '0;
				items_q   <= '0;
				emitted_q <= '0;
				drop_q    <= 1'b0;
			end else begin
				unique case (state_q)
					cse_pkg::ST_CLEAR: begin
						bucket_q <= bucket_q + cse_pkg::bucket_idx_t'(1);
					end
					cse_pkg::ST_IDLE: begin
						if (accept) begin
							last_q   <= in_last;
							bucket_q <= '0;
							if (room) begin
								if (items_q == '0 || in_bucket > largest_q) begin
									largest_q <= in_bucket;
								end
								items_q <= items_q + cse_pkg::count_t'(1);
							end else begin
								drop_q <= 1'b1;
							end
						end
					end
					cse_pkg::ST_SCAN_LOAD: begin
						if (rdata_q == '0) begin
							bucket_q <= bucket_q + cse_pkg::bucket_idx_t'(1);
						end
					end
					cse_pkg::ST_SCAN_EMIT: begin
						if (load_ready) begin
							emitted_q <= emitted_q + cse_pkg::count_t'(1);
							if (rem_q == cse_pkg::count_t'(1)) begin
								bucket_q <= bucket_q + cse_pkg::bucket_idx_t'(1);
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= in_bucket;
		end
		if (state_q == cse_pkg::ST_SCAN_LOAD) begin
			rem_q <= rdata_q;
		end else if (state_q == cse_pkg::ST_SCAN_EMIT && load_ready) begin
			rem_q <= rem_q - cse_pkg::count_t'(1);
		end
	end

endmodule

// ===== rtl/cse_out_stage.sv =====
// Output register that holds a sorted key until the receiver takes it.
module cse_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_valid,
	input  cse_pkg::cse_result_t load_data,
	output logic                 load_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cse_pkg::cse_result_t out_data
);

	logic                 valid_q;
	cse_pkg::cse_result_t data_q;

	assign load_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			data_q <= load_data;
		end
	end

endmodule

// ===== rtl/counting_sort_engine.sv =====
// Counting sort engine: top level joining the histogram core and output register.
//
// Keys enter on the in channel (in_valid/in_ready, fields in_key and in_last).
// Each counted key is first read from its bucket in the histogram memory, then
// its incremented count is written back; in_ready is low during the write back.
// A run holds at most 64 keys; later keys are taken but dropped without a write
// back, and every result of that run shows overflowed. The key with in_last set ends the run.
// After the last key the block scans buckets 0 up to the largest key seen,
// reading each bucket and then sending its sorted keys one per cycle unless
// the receiver stalls.
// Results leave on the out channel (out_valid/out_ready, fields sorted_key,
// end_of_run, overflowed) through an output register; a stalled receiver holds
// the scan on its current bucket, and no transaction is lost.
// The scan zeroes each bucket it visits, so the next run starts on a clean
// histogram. In_ready stays low during the scan.
// After reset, a clearing pass writes all 256 buckets to zero, during which
// in_ready is low.
module counting_sort_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_key,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] sorted_key,
	output logic       end_of_run,
	output logic       overflowed
);

	logic                 load_valid;
	logic                 load_ready;
	cse_pkg::cse_result_t load_data;
	cse_pkg::cse_result_t out_data;

	cse_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_key     (in_key),
		.in_last    (in_last),
		.in_ready   (in_ready),
		.load_valid (load_valid),
		.load_data  (load_data),
		.load_ready (load_ready)
	);

	cse_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_data  (load_data),
		.load_ready (load_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign sorted_key = out_data.key;
	assign end_of_run = out_data.end_run;
	assign overflowed = out_data.ovf;

endmodule

// ===== rtl/cse_checker.sv =====
// Port-level assertions for the counting sort engine, bound to the top level.
module cse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_key,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] sorted_key,
	input logic       end_of_run,
	input logic       overflowed
);

	// A pending result must stay offered until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sorted_key)
			&& $stable(end_of_run) && $stable(overflowed))
		else $error("result changed or vanished while stalled");

	// A waiting key stays offered, unchanged, until it is taken.
	a_key_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_key) && $stable(in_last))
		else $error("key changed or vanished while waiting");

	// Both channels are quiet on the cycle after a reset edge.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_ready)
		else $error("channel active during reset");

	// Taking a last key never leaves in_ready high while a valid end_of_run result is shown.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !out_valid || !end_of_run || !in_ready)
		else $error("last key accepted without entering the scan");

endmodule

bind counting_sort_engine cse_checker u_cse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.in_key     (in_key),
	.in_last    (in_last),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sorted_key (sorted_key),
	.end_of_run (end_of_run),
	.overflowed (overflowed)
);

// ===== bench/tb_counting_sort_engine.sv =====
// Self-checking testbench of the counting sort engine with a built-in sorting predictor.
`timescale 1ns / 100ps

module tb_counting_sort_engine;

	localparam int RANDOM_ITEMS = 320;
	localparam int STALL_LIMIT = 6000;
	localparam int TAIL_CYCLES = 60;

	localparam int KEYS_FULL = 0;
	localparam int KEYS_LOW = 1;
	localparam int KEYS_HIGH = 2;
	localparam int KEYS_PAIR = 3;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_key;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] sorted_key;
	logic       end_of_run;
	logic       overflowed;

	// Histogram mirror of the current run and the sorted keys still owed by the block.
	cse_pkg::count_t      hist [cse_pkg::NUM_BUCKETS];
	int                   keys_held;
	cse_pkg::bucket_idx_t top_key;
	logic                 keys_dropped;
	cse_pkg::cse_result_t sorted_q [$];

	int errors;
	int n_sent;
	int burst_left;
	int quiet_cycles;

	counting_sort_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_key    (in_key),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sorted_key(sorted_key),
		.end_of_run(end_of_run),
		.overflowed(overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic clear_hist();
		for (int b = 0; b < cse_pkg::NUM_BUCKETS; b++) begin
			hist[b] = '0;
		end
		keys_held = 0;
		top_key = '0;
		keys_dropped = 1'b0;
	endtask

	// Count one accepted key; the last key of a run releases the sorted run.
	task automatic tally_key(input logic [7:0] key, input logic last);
		cse_pkg::bucket_idx_t k;
		cse_pkg::cse_result_t r;
		int emitted;
		k = key[cse_pkg::KEY_BITS-1:0];
		if (keys_held < cse_pkg::MAX_ITEMS) begin
			hist[k] = hist[k] + 1'b1;
			if (keys_held == 0 || k > top_key) begin
				top_key = k;
			end
			keys_held++;
		end else begin
			keys_dropped = 1'b1;
		end
		if (last) begin
			emitted = 0;
			for (int b = 0; b <= int'(top_key); b++) begin
				for (int c = hist[b]; c > 0 && emitted < cse_pkg::MAX_ITEMS; c--) begin
					r.key = cse_pkg::FIELD_BITS'(b);
					r.end_run = (emitted + 1 == keys_held);
					r.ovf = keys_dropped;
					sorted_q.push_back(r);
					emitted++;
				end
			end
			clear_hist();
		end
	endtask

	// Sender works in bursts; a gap of random length may open before each burst.
	task automatic send_key(input logic [7:0] key, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_key <= key;
		in_last <= last;
		do @(posedge clk); while (!in_ready);
		tally_key(key, last);
		n_sent++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_key(input int mode, input logic [7:0] lo);
		case (mode)
			KEYS_LOW:  return 8'($urandom_range(0, 15));
			KEYS_HIGH: return 8'($urandom_range(240, 255));
			KEYS_PAIR: return lo + 8'($urandom_range(0, 1));
			default:   return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_run(input int len, input int mode);
		logic [7:0] lo;
		lo = 8'($urandom_range(0, 254));
		for (int i = 1; i <= len; i++) begin
			send_key(pick_key(mode, lo), i == len);
		end
	endtask

	task automatic test_single_key_runs();
		send_key(8'h00, 1'b1);
		send_key(8'hff, 1'b1);
		send_key(8'h55, 1'b1);
		send_key(8'haa, 1'b1);
	endtask

	task automatic test_duplicates_and_order();
		logic [7:0] mixed [6];
		mixed = '{8'd7, 8'd3, 8'd7, 8'd0, 8'd255, 8'd3};
		foreach (mixed[i]) begin
			send_key(mixed[i], i == 5);
		end
		repeat (3) send_key(8'd9, 1'b0);
		send_key(8'd9, 1'b1);
	endtask

	task automatic test_descending_keys();
		send_key(8'd200, 1'b0);
		send_key(8'd150, 1'b0);
		send_key(8'd100, 1'b0);
		send_key(8'd50, 1'b0);
		send_key(8'd1, 1'b1);
	endtask

	// Exactly at capacity: nothing is dropped and the last result is marked.
	task automatic test_full_run();
		send_run(cse_pkg::MAX_ITEMS, KEYS_FULL);
	endtask

	// Beyond capacity, including a last key that is itself dropped.
	task automatic test_overflow_run();
		send_run(cse_pkg::MAX_ITEMS + 6, KEYS_LOW);
		send_run(cse_pkg::MAX_ITEMS + 1, KEYS_HIGH);
	endtask

	task automatic test_random_runs();
		int sel;
		int len;
		while (n_sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				len = $urandom_range(1, 12);
			end else if (sel < 9) begin
				len = $urandom_range(13, 40);
			end else begin
				len = $urandom_range(cse_pkg::MAX_ITEMS - 4, cse_pkg::MAX_ITEMS + 8);
			end
			send_run(len, $urandom_range(KEYS_FULL, KEYS_PAIR));
		end
	endtask

	task automatic wait_drained();
		while (sorted_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Receiver stalls on a repeating 8-bit ready pattern that always has a ready bit set and is redrawn periodically.
	initial begin
		logic [7:0] pattern;
		int slot;
		out_ready = 1'b0;
		pattern = 8'hff;
		slot = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (slot % 32 == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					pattern = 8'hff;
				end else begin
					pattern = 8'($urandom_range(0, 255)) | (8'h01 << $urandom_range(0, 7));
				end
			end
			out_ready <= pattern[slot % 8];
			slot++;
		end
	end

	always @(posedge clk) begin
		cse_pkg::cse_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (sorted_q.size() == 0) begin
				$error("unexpected transaction: sorted_key=%0d end_of_run=%0b overflowed=%0b",
					sorted_key, end_of_run, overflowed);
				errors++;
			end else begin
				exp_r = sorted_q.pop_front();
				if (sorted_key !== exp_r.key) begin
					$error("sorted_key: expected %0d, got %0d", exp_r.key, sorted_key);
					errors++;
				end
				if (end_of_run !== exp_r.end_run) begin
					$error("end_of_run: expected %0b, got %0b", exp_r.end_run, end_of_run);
					errors++;
				end
				if (overflowed !== exp_r.ovf) begin
					$error("overflowed: expected %0b, got %0b", exp_r.ovf, overflowed);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("counting_sort_engine regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_key = '0;
		in_last = 1'b0;
		errors = 0;
		n_sent = 0;
		burst_left = 0;
		quiet_cycles = 0;
		clear_hist();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_key_runs();
		test_duplicates_and_order();
		test_descending_keys();
		test_full_run();
		test_overflow_run();
		test_random_runs();
		release_input();
		wait_drained();

		if (errors == 0) begin
			$display("counting_sort_engine regression: pass");
		end else begin
			$display("counting_sort_engine regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cse_pkg.sv
rtl/cse_core.sv
rtl/cse_out_stage.sv
rtl/counting_sort_engine.sv
rtl/cse_checker.sv
bench/tb_counting_sort_engine.sv
